// File: rtl/core/lbst_pkg.sv
// Shared constants and types for the line versus box slab test.
`default_nettype none
package lbst_pkg;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_AXES       = 3;
  localparam int NUM_LANES      = 2 * NUM_AXES;
  localparam int TW             = 64;
  localparam int TW_WIDE        = 128;
  localparam int CAP_BIT        = 62;
  localparam logic signed [TW-1:0] T_CAP     = 64'sh4000_0000_0000_0000;
  localparam logic signed [TW-1:0] T_CAP_NEG = -64'sh4000_0000_0000_0000;

  // Per-item control carried alongside the divider lanes
  typedef struct packed {
    logic [NUM_LANES-1:0] neg;
    logic [NUM_AXES-1:0]  zero;
    logic [NUM_AXES-1:0]  below;
    logic [NUM_AXES-1:0]  above;
  } side_t;

  function automatic int latency(input int cb, input int fb);
    return cb + 1 + fb + 4;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/line_box_slab_test.sv
// Top level: fully pipelined line versus axis-aligned box slab test.
//
// Usage:
//   Input channel: drive the twelve in_* coordinates (signed fixed point,
//   COORD_BITS wide, FRAC_BITS fraction bits) and raise start. A transaction
//   is taken at each rising edge with start high and busy low; busy stays
//   low, so one transaction can enter every cycle.
//   Result channel: out_valid is high for exactly one cycle with out_hit,
//   out_t_enter and out_t_exit; results leave in input order.
//   Throughput: one per cycle. The path is six restoring dividers, one
//   quotient bit per stage (COORD_BITS + 1 + FRAC_BITS stages), plus input
//   prep, ordering, min/max fold and output saturation stages. The default
//   format is Q16.16.
//   Reset (rst_n low, synchronous) drops every transaction in flight.
//   The receiver cannot stall, so nothing is held back.
`default_nettype none
module line_box_slab_test
  import lbst_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_box_min_x,
  input  wire logic signed [COORD_BITS-1:0] in_box_min_y,
  input  wire logic signed [COORD_BITS-1:0] in_box_min_z,
  input  wire logic signed [COORD_BITS-1:0] in_box_max_x,
  input  wire logic signed [COORD_BITS-1:0] in_box_max_y,
  input  wire logic signed [COORD_BITS-1:0] in_box_max_z,
  input  wire logic signed [COORD_BITS-1:0] in_origin_x,
  input  wire logic signed [COORD_BITS-1:0] in_origin_y,
  input  wire logic signed [COORD_BITS-1:0] in_origin_z,
  input  wire logic signed [COORD_BITS-1:0] in_dir_x,
  input  wire logic signed [COORD_BITS-1:0] in_dir_y,
  input  wire logic signed [COORD_BITS-1:0] in_dir_z,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic signed [COORD_BITS-1:0]      out_t_enter,
  output logic signed [COORD_BITS-1:0]      out_t_exit
);
  localparam int CB = COORD_BITS;
  localparam int NW = CB + 1;          // numerator magnitude
  localparam int QW = NW + FRAC_BITS;  // quotient bits = divider stages

  logic signed [CB-1:0] bmin [NUM_AXES];
  logic signed [CB-1:0] bmax [NUM_AXES];
  logic signed [CB-1:0] org  [NUM_AXES];
  logic signed [CB-1:0] dir  [NUM_AXES];

  assign bmin = '{in_box_min_x, in_box_min_y, in_box_min_z};
  assign bmax = '{in_box_max_x, in_box_max_y, in_box_max_z};
  assign org  = '{in_origin_x, in_origin_y, in_origin_z};
  assign dir  = '{in_dir_x, in_dir_y, in_dir_z};
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // Divider pipeline: stage 0 is the prep register
  logic          v_r    [QW+1];
  side_t         side_r [QW+1];
  logic [CB-1:0] rem_r  [QW+1][NUM_LANES];
  logic [QW-1:0] x_r    [QW+1][NUM_LANES];
  logic [CB-1:0] d_r    [QW+1][NUM_LANES];

  side_t         side_nxt;
  logic [QW-1:0] x_nxt [NUM_LANES];
  logic [CB-1:0] d_nxt [NUM_LANES];

  always_comb begin
    logic signed [CB:0] num;
    logic [NW-1:0]      mag;
    logic [CB-1:0]      dmag;
    side_nxt = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      side_nxt.zero[a]  = (dir[a] == '0);
      side_nxt.below[a] = (org[a] < bmin[a]) && (org[a] < bmax[a]);
      side_nxt.above[a] = (org[a] > bmin[a]) && (org[a] > bmax[a]);
      dmag = dir[a][CB-1] ? CB'(-dir[a]) : CB'(dir[a]);
      if (side_nxt.zero[a]) begin
        dmag = CB'(1);
      end
      for (int s = 0; s < 2; s++) begin
        num = (s == 0) ? ((CB+1)'(bmin[a]) - (CB+1)'(org[a]))
                       : ((CB+1)'(bmax[a]) - (CB+1)'(org[a]));
        mag = num[CB] ? NW'(-num) : NW'(num);
        side_nxt.neg[2*a+s] = num[CB] ^ dir[a][CB-1];
        x_nxt[2*a+s] = {mag, {FRAC_BITS{1'b0}}};
        d_nxt[2*a+s] = dmag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= accept;
    end
    side_r[0] <= side_nxt;
    for (int l = 0; l < NUM_LANES; l++) begin
      rem_r[0][l] <= '0;
      x_r[0][l]   <= x_nxt[l];
      d_r[0][l]   <= d_nxt[l];
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_div
    logic [CB-1:0] rem_nxt [NUM_LANES];
    logic [QW-1:0] xs_nxt  [NUM_LANES];

    always_comb begin
      logic [CB:0] trial;
      logic [CB:0] diff;
      for (int l = 0; l < NUM_LANES; l++) begin
        trial = {rem_r[s-1][l], x_r[s-1][l][QW-1]};
        diff  = trial - {1'b0, d_r[s-1][l]};
        if (trial >= {1'b0, d_r[s-1][l]}) begin
          rem_nxt[l] = diff[CB-1:0];
          xs_nxt[l]  = {x_r[s-1][l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[CB-1:0];
          xs_nxt[l]  = {x_r[s-1][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_r[s-1];
      end
      side_r[s] <= side_r[s-1];
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_r[s][l] <= rem_nxt[l];
        x_r[s][l]   <= xs_nxt[l];
        d_r[s][l]   <= d_r[s-1][l];
      end
    end
  end

  // Sign, cap and order the two parameters of each axis
  logic                 ord_v_r;
  logic [NUM_AXES-1:0]  ord_below_r, ord_above_r;
  logic signed [TW-1:0] a_r [NUM_AXES];
  logic signed [TW-1:0] b_r [NUM_AXES];
  logic signed [TW-1:0] a_nxt [NUM_AXES];
  logic signed [TW-1:0] b_nxt [NUM_AXES];

  always_comb begin
    logic [TW_WIDE-1:0]   qw;
    logic signed [TW-1:0] mag;
    logic signed [TW-1:0] t [2];
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int s = 0; s < 2; s++) begin
        qw = TW_WIDE'(x_r[QW][2*a+s]);
        mag = (|qw[TW_WIDE-1:CAP_BIT]) ? T_CAP : {2'b00, qw[CAP_BIT-1:0]};
        t[s] = side_r[QW].neg[2*a+s] ? -mag : mag;
      end
      if (side_r[QW].zero[a]) begin
        a_nxt[a] = T_CAP_NEG;
        b_nxt[a] = T_CAP;
      end else if (t[0] < t[1]) begin
        a_nxt[a] = t[0];
        b_nxt[a] = t[1];
      end else begin
        a_nxt[a] = t[1];
        b_nxt[a] = t[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_v_r <= 1'b0;
    end else begin
      ord_v_r <= v_r[QW];
    end
    ord_below_r <= side_r[QW].below & side_r[QW].zero;
    ord_above_r <= side_r[QW].above & side_r[QW].zero;
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  // Fold the axes into one entry and one exit
  logic                 fold_v_r, fail_r;
  logic signed [TW-1:0] entry_r, exit_r;
  logic signed [TW-1:0] entry_nxt, exit_nxt;

  always_comb begin
    entry_nxt = a_r[0];
    exit_nxt  = b_r[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (a_r[a] > entry_nxt) entry_nxt = a_r[a];
      if (b_r[a] < exit_nxt)  exit_nxt  = b_r[a];
    end
    if (|ord_below_r) entry_nxt = T_CAP;
    if (|ord_above_r) exit_nxt  = T_CAP_NEG;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_v_r <= 1'b0;
    end else begin
      fold_v_r <= ord_v_r;
    end
    fail_r  <= |(ord_below_r | ord_above_r);
    entry_r <= entry_nxt;
    exit_r  <= exit_nxt;
  end

  // Hit decision and output saturation
  localparam logic signed [TW-1:0] OUT_HI = TW'((65'sd1 <<< (CB - 1)) - 65'sd1);
  localparam logic signed [TW-1:0] OUT_LO = -OUT_HI - TW'(1);

  logic                 out_valid_r, out_hit_r;
  logic signed [CB-1:0] out_t_enter_r, out_t_exit_r;

  function automatic logic signed [CB-1:0] sat_out(input logic signed [TW-1:0] t);
    logic signed [TW-1:0] c;
    c = t;
    if (c > OUT_HI) c = OUT_HI;
    if (c < OUT_LO) c = OUT_LO;
    return c[CB-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fold_v_r;
    end
    out_hit_r     <= ~fail_r && (exit_r >= entry_r);
    out_t_enter_r <= sat_out(entry_r);
    out_t_exit_r  <= sat_out(exit_r);
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_t_enter = out_t_enter_r;
  assign out_t_exit  = out_t_exit_r;
endmodule
`default_nettype wire

// File: rtl/core/lbst_checker.sv
// Port-level checks for the slab test, bound onto the top level.
`default_nettype none
module lbst_checker
  import lbst_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic                         out_hit,
  input wire logic signed [COORD_BITS-1:0] out_t_enter,
  input wire logic signed [COORD_BITS-1:0] out_t_exit
);
  // edges from the accepting edge to the edge that samples the strobe
  localparam int LAT = latency(COORD_BITS, FRAC_BITS);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> $past(start && rst_n, LAT))
    else $error("result without a transaction accepted earlier");

  a_hit_ordered: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_hit) |-> (out_t_exit >= out_t_enter))
    else $error("hit reported with exit before entry");

  a_strobe_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
      $rose(rst_n) |-> !out_valid)
    else $error("result strobe right after reset");
endmodule

bind line_box_slab_test lbst_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_lbst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_hit    (out_hit),
  .out_t_enter(out_t_enter),
  .out_t_exit (out_t_exit)
);
`default_nettype wire

// File: dv/testbench.sv
// Testbench for the line versus axis-aligned box slab test, self-checking.
`timescale 1ns / 1ps
module testbench;
  import lbst_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int PIPE_CYCLES = CB + FB + 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint SLAB_INF = 64'sd1 <<< 62;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] ONE = 1 <<< FB;

  typedef struct {
    logic signed [CB-1:0] bmin[3];
    logic signed [CB-1:0] bmax[3];
    logic signed [CB-1:0] org[3];
    logic signed [CB-1:0] dir[3];
  } line_box_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CB-1:0] t_enter;
    logic signed [CB-1:0] t_exit;
  } slab_res_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [CB-1:0] in_box_min_x, in_box_min_y, in_box_min_z;
  logic signed [CB-1:0] in_box_max_x, in_box_max_y, in_box_max_z;
  logic signed [CB-1:0] in_origin_x, in_origin_y, in_origin_z;
  logic signed [CB-1:0] in_dir_x, in_dir_y, in_dir_z;
  logic out_valid;
  logic out_hit;
  logic signed [CB-1:0] out_t_enter;
  logic signed [CB-1:0] out_t_exit;

  slab_res_t pending_hits[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int hits_seen = 0;
  int cycles = 0;

  line_box_slab_test dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_box_min_x(in_box_min_x), .in_box_min_y(in_box_min_y),
    .in_box_min_z(in_box_min_z), .in_box_max_x(in_box_max_x),
    .in_box_max_y(in_box_max_y), .in_box_max_z(in_box_max_z),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y),
    .in_origin_z(in_origin_z), .in_dir_x(in_dir_x), .in_dir_y(in_dir_y),
    .in_dir_z(in_dir_z), .out_valid(out_valid), .out_hit(out_hit),
    .out_t_enter(out_t_enter), .out_t_exit(out_t_exit)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic signed [CB-1:0] clamp_t(input longint t);
    if (t > longint'(CMAX)) return CMAX;
    if (t < longint'(CMIN)) return CMIN;
    return t[CB-1:0];
  endfunction

  function automatic slab_res_t predict_slab(input line_box_t b);
    slab_res_t r;
    longint entry, leave, t1, t2, lo, hi, o;
    bit miss;
    entry = -SLAB_INF;
    leave = SLAB_INF;
    miss = 1'b0;
    for (int k = 0; k < 3; k++) begin
      o = longint'(b.org[k]);
      if (b.dir[k] == 0) begin
        lo = (b.bmin[k] < b.bmax[k]) ? longint'(b.bmin[k]) : longint'(b.bmax[k]);
        hi = (b.bmin[k] < b.bmax[k]) ? longint'(b.bmax[k]) : longint'(b.bmin[k]);
        if (o < lo) begin
          miss = 1'b1;
          entry = SLAB_INF;
        end else if (o > hi) begin
          miss = 1'b1;
          leave = -SLAB_INF;
        end
      end else begin
        // quotient fits easily in 64 bits; SV division truncates toward zero
        t1 = ((longint'(b.bmin[k]) - o) * (64'sd1 <<< FB)) / longint'(b.dir[k]);
        t2 = ((longint'(b.bmax[k]) - o) * (64'sd1 <<< FB)) / longint'(b.dir[k]);
        if (t1 > t2) begin
          lo = t2;
          t2 = t1;
          t1 = lo;
        end
        if (t1 > entry) entry = t1;
        if (t2 < leave) leave = t2;
      end
    end
    r.hit = !miss && (leave >= entry);
    r.t_enter = clamp_t(entry);
    r.t_exit = clamp_t(leave);
    return r;
  endfunction

  // Drive one transaction and hold it until taken; start is left high.
  task automatic send_line(input line_box_t b);
    start <= 1'b1;
    in_box_min_x <= b.bmin[0]; in_box_min_y <= b.bmin[1]; in_box_min_z <= b.bmin[2];
    in_box_max_x <= b.bmax[0]; in_box_max_y <= b.bmax[1]; in_box_max_z <= b.bmax[2];
    in_origin_x <= b.org[0]; in_origin_y <= b.org[1]; in_origin_z <= b.org[2];
    in_dir_x <= b.dir[0]; in_dir_y <= b.dir[1]; in_dir_z <= b.dir[2];
    do @(posedge clk); while (busy);
    pending_hits = {pending_hits, predict_slab(b)};
    sent++;
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    slab_res_t want;
    if (rst_n && out_valid) begin
      checked++;
      if (out_hit) hits_seen++;
      if (pending_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected result hit=%0b enter=%0d exit=%0d",
                 $time, out_hit, out_t_enter, out_t_exit);
      end else begin
        want = pending_hits.pop_front();
        if (out_hit !== want.hit) begin
          errors++;
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_hit);
        end
        if (out_t_enter !== want.t_enter) begin
          errors++;
          $display("%0t: t_enter expected %0d actual %0d",
                   $time, want.t_enter, out_t_enter);
        end
        if (out_t_exit !== want.t_exit) begin
          errors++;
          $display("%0t: t_exit expected %0d actual %0d",
                   $time, want.t_exit, out_t_exit);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_hits.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [CB-1:0] near_coord();
    return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  function automatic line_box_t uniform_line(input logic signed [CB-1:0] v);
    line_box_t b;
    for (int k = 0; k < 3; k++) begin
      b.bmin[k] = -v; b.bmax[k] = v; b.org[k] = 0; b.dir[k] = ONE;
    end
    return b;
  endfunction

  // Box with random content and a line aimed near it; sometimes axis-parallel.
  function automatic line_box_t aimed_line();
    line_box_t b;
    for (int k = 0; k < 3; k++) begin
      b.bmin[k] = near_coord();
      b.bmax[k] = b.bmin[k] + $signed($urandom_range(0, 32'h0010_0000));
      if ($urandom_range(0, 15) == 0) b.bmax[k] = b.bmin[k] - 32'sh0001_0000;
      b.org[k] = near_coord();
      b.dir[k] = ((b.bmin[k] >>> 1) + (b.bmax[k] >>> 1)) - b.org[k]
                 + ($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
      case ($urandom_range(0, 9))
        0: b.dir[k] = 0;
        1: b.dir[k] = $signed($urandom_range(0, 16)) - 8;
        default: ;
      endcase
    end
    return b;
  endfunction

  function automatic line_box_t noise_line();
    line_box_t b;
    for (int k = 0; k < 3; k++) begin
      b.bmin[k] = $urandom; b.bmax[k] = $urandom;
      b.org[k] = $urandom; b.dir[k] = $urandom;
      if ($urandom_range(0, 7) == 0) b.dir[k] = 0;
      if ($urandom_range(0, 7) == 0) b.dir[k] = $urandom_range(0, 1) ? CMIN : CMAX;
    end
    return b;
  endfunction

  task automatic test_directed();
    line_box_t b;
    send_line(uniform_line(ONE));                 // unit box, diagonal line
    b = uniform_line(ONE); b.org[0] = -5 * ONE;   // origin outside in x, miss
    send_line(b);
    b = uniform_line(ONE); b.dir[1] = 0;          // zero dir, origin inside
    send_line(b);
    b.org[1] = ONE;                               // zero dir, origin on bound
    send_line(b);
    b.org[1] = -2 * ONE;                          // zero dir, below slab
    send_line(b);
    b.org[1] = 2 * ONE;                           // zero dir, above slab
    send_line(b);
    b = uniform_line(ONE);                        // all directions zero
    for (int k = 0; k < 3; k++) b.dir[k] = 0;
    send_line(b);
    b = uniform_line(ONE); b.bmin[2] = ONE; b.bmax[2] = -ONE;  // inverted box
    send_line(b);
    b = uniform_line(ONE); b.dir[0] = -ONE; b.dir[2] = 1;      // tiny step
    send_line(b);
    b = uniform_line(CMAX);                       // extreme bounds, huge t
    for (int k = 0; k < 3; k++) begin
      b.bmin[k] = CMIN; b.org[k] = CMAX; b.dir[k] = 1;
    end
    send_line(b);
    for (int k = 0; k < 3; k++) begin
      b.bmin[k] = CMAX; b.bmax[k] = CMIN; b.org[k] = CMIN; b.dir[k] = -1;
    end
    send_line(b);
    for (int k = 0; k < 3; k++) b.dir[k] = CMIN;
    send_line(b);
    for (int k = 0; k < 3; k++) b.dir[k] = CMAX;
    send_line(b);
    b = uniform_line(0);                          // degenerate point box
    send_line(b);
    b = uniform_line(ONE);                        // disjoint slabs: miss
    b.org[0] = 3 * ONE; b.dir[1] = -ONE;
    send_line(b);
    for (int k = 0; k < 3; k++) begin             // all ones pattern
      b.bmin[k] = -1; b.bmax[k] = -1; b.org[k] = -1; b.dir[k] = -1;
    end
    send_line(b);
  endtask

  task automatic test_random_aimed(input int n);
    for (int i = 0; i < n; i++) begin
      send_line(aimed_line());
      maybe_idle(1'b1);
    end
  endtask

  task automatic test_random_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_line(noise_line());
      maybe_idle(1'b1);
    end
  endtask

  // Last part: one transaction every cycle, no gaps.
  task automatic test_back_to_back(input int n);
    for (int i = 0; i < n; i++) begin
      send_line($urandom_range(0, 3) == 0 ? noise_line() : aimed_line());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_box_min_x <= 0; in_box_min_y <= 0; in_box_min_z <= 0;
    in_box_max_x <= 0; in_box_max_y <= 0; in_box_max_z <= 0;
    in_origin_x <= 0; in_origin_y <= 0; in_origin_z <= 0;
    in_dir_x <= 0; in_dir_y <= 0; in_dir_z <= 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_aimed(900);
    test_random_noise(300);
    test_back_to_back(250);
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 10) @(posedge clk);
    $display("covered %0d line/box tests, %0d results checked, %0d hits",
             sent, checked, hits_seen);
    $display("directed extremes, zero-direction and inverted boxes, aimed and noise random");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/lbst_pkg.sv
rtl/core/line_box_slab_test.sv
rtl/core/lbst_checker.sv
dv/testbench.sv
